// ===== hw/rtl/rgr_pkg.sv =====
`timescale 1ns / 1ps

package rgr_pkg;

    // fixed port widths of the item fields
    localparam int IN_W  = 16;
    localparam int RES_W = 33;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_ADD = 2'd0;
    localparam opcode_t OP_SUB = 2'd1;
    localparam opcode_t OP_MUL = 2'd2;
    localparam opcode_t OP_DIV = 2'd3;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_ZERO_DEN = 1'b1;

endpackage

// ===== hw/rtl/rgr_in_if.sv =====
`timescale 1ns / 1ps

interface rgr_in_if import rgr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    opcode_t                opcode;
    logic signed [IN_W-1:0] a_num;
    logic signed [IN_W-1:0] a_den;
    logic signed [IN_W-1:0] b_num;
    logic signed [IN_W-1:0] b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

// ===== hw/rtl/rgr_out_if.sv =====
`timescale 1ns / 1ps

interface rgr_out_if import rgr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== hw/rtl/rational_arith_gcd_reduce_top.sv =====
`timescale 1ns / 1ps

// Rational add, subtract, multiply and divide with gcd reduction. One item is
// taken when ready is high; ready stays low until that item's result is in the
// output register, which holds it until taken while the next item may enter.
// An item passes through three products on the single shared multiplier, a
// binary gcd loop of one shift or subtract per cycle, and two passes of a one
// bit per cycle divider. A zero raw denominator skips gcd and division and
// returns 0/0 with status set. The denominator keeps the sign the cross
// product gives.
module rational_arith_gcd_reduce_top import rgr_pkg::*; #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rgr_in_if.sink    in,
    rgr_out_if.source out
);

    localparam int OW = OPERAND_WIDTH;
    localparam int NW = 2 * OW + 1;
    localparam int IW = (OW > IN_W) ? OW : IN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIVN = 3'd4;
    localparam logic [2:0] S_DIVD = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]              state_reg;
    logic [1:0]              cnt_reg;
    opcode_t                 op_reg;
    logic signed [OW-1:0]    an_reg;
    logic signed [OW-1:0]    ad_reg;
    logic signed [OW-1:0]    bn_reg;
    logic signed [OW-1:0]    bd_reg;
    logic signed [2*OW-1:0]  prod_reg;
    logic signed [NW-1:0]    num_reg;
    logic signed [NW-1:0]    den_reg;
    logic [NW-1:0]           g_reg;
    logic signed [RES_W-1:0] rnum_reg;
    logic signed [RES_W-1:0] rden_reg;
    logic                    rstat_reg;
    logic                    ovalid_reg;
    logic signed [RES_W-1:0] onum_reg;
    logic signed [RES_W-1:0] oden_reg;
    logic                    ostat_reg;

    logic signed [OW-1:0]    mx;
    logic signed [OW-1:0]    my;
    logic signed [NW-1:0]    prod_ext;
    logic [NW-1:0]           num_mag;
    logic [NW-1:0]           den_mag;
    logic                    gcd_start;
    logic                    gcd_done;
    logic [NW-1:0]           gcd_g;
    logic                    div_start;
    logic [NW-1:0]           div_dividend;
    logic                    div_done;
    logic [NW-1:0]           div_q;
    logic [NW-1:0]           q_neg;
    logic signed [RES_W-1:0] q_res;
    logic                    in_fire;
    logic                    out_load;

    // take OPERAND_WIDTH low bits of a port field as a signed value (zero-extended if wider than the port)
    function automatic logic signed [OW-1:0] op_ext(input logic [IN_W-1:0] v);
        logic [IW-1:0] z;
        z = IW'(v);
        return $signed(z[OW-1:0]);
    endfunction

    assign in_fire  = in.valid && in.ready;
    assign in.ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!ovalid_reg || out.ready);

    // shared multiplier operand select, one product per cycle
    always_comb
    begin
        mx = (cnt_reg == 2'd0) ? an_reg : ad_reg;
        case (cnt_reg)
            2'd0:    my = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            2'd1:    my = (op_reg == OP_MUL) ? bd_reg : bn_reg;
            default: my = (op_reg == OP_DIV) ? bn_reg : bd_reg;
        endcase
    end

    assign prod_ext = NW'(prod_reg);
    assign num_mag  = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign den_mag  = den_reg[NW-1] ? NW'(-den_reg) : NW'(den_reg);

    assign gcd_start    = (state_reg == S_CHK) && (den_reg != '0);
    assign div_start    = ((state_reg == S_GCD) && gcd_done)
                       || ((state_reg == S_DIVN) && div_done);
    assign div_dividend = (state_reg == S_GCD) ? num_mag : den_mag;

    // restore the sign of the value just divided
    always_comb
    begin
        q_neg = NW'(0) - div_q;
        if ((state_reg == S_DIVN) ? num_reg[NW-1] : den_reg[NW-1])
            q_res = RES_W'($signed(q_neg));
        else
            q_res = RES_W'($signed(div_q));
    end

    rgr_gcd #(.W(NW)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .a_in  (num_mag),
        .b_in  (den_mag),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rgr_div #(.W(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((state_reg == S_GCD) ? gcd_g : g_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= in.opcode;
                        an_reg    <= op_ext(in.a_num);
                        ad_reg    <= op_ext(in.a_den);
                        bn_reg    <= op_ext(in.b_num);
                        bd_reg    <= op_ext(in.b_den);
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= mx * my;
                    cnt_reg  <= cnt_reg + 1'b1;
                    case (cnt_reg)
                        2'd1: num_reg <= prod_ext;
                        2'd2:
                        begin
                            if (op_reg == OP_ADD)
                                num_reg <= num_reg + prod_ext;
                            else if (op_reg == OP_SUB)
                                num_reg <= num_reg - prod_ext;
                        end
                        2'd3:
                        begin
                            den_reg   <= prod_ext;
                            state_reg <= S_CHK;
                        end
                        default: ;
                    endcase
                end
                S_CHK:
                begin
                    if (den_reg == '0)
                    begin
                        rnum_reg  <= '0;
                        rden_reg  <= '0;
                        rstat_reg <= STATUS_ZERO_DEN;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    if (gcd_done)
                    begin
                        g_reg     <= gcd_g;
                        state_reg <= S_DIVN;
                    end
                end
                S_DIVN:
                begin
                    if (div_done)
                    begin
                        rnum_reg  <= q_res;
                        state_reg <= S_DIVD;
                    end
                end
                S_DIVD:
                begin
                    if (div_done)
                    begin
                        rden_reg  <= q_res;
                        rstat_reg <= STATUS_OK;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (out_load)
            ovalid_reg <= 1'b1;
        else if (out.ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            onum_reg  <= rnum_reg;
            oden_reg  <= rden_reg;
            ostat_reg <= rstat_reg;
        end
    end

    assign out.valid   = ovalid_reg;
    assign out.res_num = onum_reg;
    assign out.res_den = oden_reg;
    assign out.status  = ostat_reg;

    // checks
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in.ready)
        else $error("input ready while an item is in flight");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (div_start && (state_reg == S_GCD)) |-> (gcd_g != '0))
        else $error("division started with zero gcd");

    a_zero_den_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && (out.status == STATUS_ZERO_DEN)) |->
        ((out.res_num == '0) && (out.res_den == '0)))
        else $error("zero denominator result is not 0/0");

endmodule

// ===== hw/rtl/rgr_gcd.sv =====
`timescale 1ns / 1ps

module rgr_gcd #(
    parameter int W = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output logic         done,
    output logic [W-1:0] g
);

    localparam int KW = $clog2(W + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    logic [1:0]    state_reg;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  g_reg;
    logic [KW-1:0] k_reg;
    logic          done_reg;

    // binary gcd: one shift or one subtract per cycle, then restore common twos
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a_in;
                        b_reg     <= b_in;
                        k_reg     <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (a_reg == '0)
                    begin
                        g_reg     <= b_reg;
                        state_reg <= S_SHIFT;
                    end
                    else if (b_reg == '0)
                    begin
                        g_reg     <= a_reg;
                        state_reg <= S_SHIFT;
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!a_reg[0])
                        a_reg <= a_reg >> 1;
                    else if (!b_reg[0])
                        b_reg <= b_reg >> 1;
                    else if (a_reg >= b_reg)
                        a_reg <= a_reg - b_reg;
                    else
                        b_reg <= b_reg - a_reg;
                end
                S_SHIFT:
                begin
                    if (k_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        g_reg <= g_reg << 1;
                        k_reg <= k_reg - 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign g    = g_reg;

endmodule

// ===== hw/rtl/rgr_div.sv =====
`timescale 1ns / 1ps

module rgr_div #(
    parameter int W = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  q_reg;
    logic [W-1:0]  d_reg;
    logic [W:0]    rem_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg[W-1:0], q_reg[W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    q_reg    <= dividend;
                    d_reg    <= divisor;
                    rem_reg  <= '0;
                    cnt_reg  <= CW'(W);
                end
            end
            else
            begin
                rem_reg <= fits ? diff : trial;
                q_reg   <= {q_reg[W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
